### rtl/core/tsg_pkg.sv
package tsg_pkg;

    // Sizing
    localparam int SLOTS           = 16;
    localparam int SLOT_W          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GESTURE_ENTRIES = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int Q_PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CORDIC_STEPS    = 15;
    localparam int ENTRY_W         = 13;

    // Angles in 1/256 degree
    localparam logic [16:0] ANG_45  = 17'd11520;
    localparam logic [16:0] ANG_90  = 17'd23040;
    localparam logic [16:0] ANG_180 = 17'd46080;
    localparam logic [16:0] ANG_270 = 17'd69120;

    // Event codes
    typedef enum logic [1:0] {
        FN_DOWN   = 2'd0,
        FN_MOTION = 2'd1,
        FN_UP     = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    // Register indexes
    typedef enum logic [2:0] {
        REG_DIST_THR  = 3'd0,
        REG_LENIENCY  = 3'd1,
        REG_TIMEOUT   = 3'd2,
        REG_ORIENT    = 3'd3,
        REG_EDGE_SIZE = 3'd4,
        REG_SCREEN    = 3'd5,
        REG_TAB_LO    = 3'd6,
        REG_TAB_HI    = 3'd7
    } reg_idx_t;

    localparam logic [3:0] SWIPE_NONE  = 4'd8;
    localparam logic [3:0] EDGE_ANY    = 4'd0;
    localparam logic [3:0] EDGE_NONE   = 4'd1;
    localparam logic [3:0] EDGE_LEFT   = 4'd2;
    localparam logic [3:0] EDGE_RIGHT  = 4'd3;
    localparam logic [3:0] EDGE_TOP    = 4'd4;
    localparam logic [3:0] EDGE_BOTTOM = 4'd5;
    localparam logic [3:0] EDGE_TL     = 4'd6;
    localparam logic [3:0] EDGE_TR     = 4'd7;
    localparam logic [3:0] EDGE_BL     = 4'd8;
    localparam logic [3:0] EDGE_BR     = 4'd9;

    // One queued event for the back end
    typedef struct packed {
        func_t       func;
        logic        up_ok;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
    } job_t;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [15:0] dist_thr;
        logic [7:0]  leniency;
        logic [15:0] timeout;
        logic [1:0]  orient;
        logic [31:0] edge_sizes;
        logic [31:0] screen_size;
        logic [51:0] tab_lo;
        logic [51:0] tab_hi;
    } cfg_t;

    // atan(2^-i) in 1/256 degree
    function automatic logic [13:0] atan_step(input logic [3:0] i);
        logic [13:0] r;
        case (i)
            4'd0:    r = 14'd11520;
            4'd1:    r = 14'd6801;
            4'd2:    r = 14'd3593;
            4'd3:    r = 14'd1824;
            4'd4:    r = 14'd916;
            4'd5:    r = 14'd458;
            4'd6:    r = 14'd229;
            4'd7:    r = 14'd115;
            4'd8:    r = 14'd57;
            4'd9:    r = 14'd29;
            4'd10:   r = 14'd14;
            4'd11:   r = 14'd7;
            4'd12:   r = 14'd4;
            4'd13:   r = 14'd2;
            4'd14:   r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    // Swipe code of each 45 degree window, starting straight up
    function automatic logic [3:0] window_code(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd4;
            4'd2:    r = 4'd2;
            4'd3:    r = 4'd7;
            4'd4:    r = 4'd1;
            4'd5:    r = 4'd6;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd0;
            default: r = SWIPE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] swipe_turn(input logic [2:0] s);
        logic [2:0] r;
        case (s)
            3'd0:    r = 3'd2;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd0;
            3'd4:    r = 3'd7;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd5;
            default: r = 3'd6;
        endcase
        return r;
    endfunction

    // Any, none and the codes above the corners stay as they are
    function automatic logic [3:0] edge_turn(input logic [3:0] e);
        logic [3:0] r;
        case (e)
            EDGE_LEFT:   r = EDGE_TOP;
            EDGE_RIGHT:  r = EDGE_BOTTOM;
            EDGE_TOP:    r = EDGE_RIGHT;
            EDGE_BOTTOM: r = EDGE_LEFT;
            EDGE_TL:     r = EDGE_TR;
            EDGE_TR:     r = EDGE_BR;
            EDGE_BL:     r = EDGE_TL;
            EDGE_BR:     r = EDGE_BL;
            default:     r = e;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] rot_swipe(input logic [2:0] s, input logic [1:0] n);
        logic [2:0] r;
        r = s;
        for (int t = 0; t < 3; t++) begin
            if (t < int'(n)) r = swipe_turn(r);
        end
        return r;
    endfunction

    function automatic logic [3:0] rot_edge(input logic [3:0] e, input logic [1:0] n);
        logic [3:0] r;
        r = e;
        for (int t = 0; t < 3; t++) begin
            if (t < int'(n)) r = edge_turn(r);
        end
        return r;
    endfunction

endpackage

### rtl/core/touch_swipe_gesture_recognizer.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   func, slot, pos_x, pos_y
// result    out        out_valid / out_stall swipe_code, finger_count, edge_code, match_mask
// config    in         APB psel/penable      paddr (8-byte registers), pwdata, prdata
//
// The front takes one event per cycle into a four-entry queue; it stalls only when full.
// Ticks, downs and lifts without a full point pair retire straight from the idle state.
// A complete lift runs squares, 15-step shared CORDIC, classify and finish states.
// Reset clears all slot valid bits, counters and the result register; no clearing pass.
// A held result stalls the back end only when the next result is ready to be written.
module touch_swipe_gesture_recognizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  slot,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  swipe_code,
    output logic [4:0]  finger_count,
    output logic [3:0]  edge_code,
    output logic [7:0]  match_mask,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import tsg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     q_full, q_empty, push, pop;
    job_t     push_job, head;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[5:3]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_thr    <= 16'd200;
            cfg_reg.leniency    <= 8'd20;
            cfg_reg.timeout     <= 16'd400;
            cfg_reg.orient      <= 2'd0;
            cfg_reg.edge_sizes  <= 32'd3276850;
            cfg_reg.screen_size <= '0;
            cfg_reg.tab_lo      <= '0;
            cfg_reg.tab_hi      <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (widx)
                REG_DIST_THR:  cfg_reg.dist_thr    <= pwdata[15:0];
                REG_LENIENCY:  cfg_reg.leniency    <= pwdata[7:0];
                REG_TIMEOUT:   cfg_reg.timeout     <= pwdata[15:0];
                REG_ORIENT:    cfg_reg.orient      <= pwdata[1:0];
                REG_EDGE_SIZE: cfg_reg.edge_sizes  <= pwdata[31:0];
                REG_SCREEN:    cfg_reg.screen_size <= pwdata[31:0];
                REG_TAB_LO:    cfg_reg.tab_lo      <= pwdata[51:0];
                REG_TAB_HI:    cfg_reg.tab_hi      <= pwdata[51:0];
                default:       cfg_reg.orient      <= cfg_reg.orient;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (widx)
            REG_DIST_THR:  prdata = {48'd0, cfg_reg.dist_thr};
            REG_LENIENCY:  prdata = {56'd0, cfg_reg.leniency};
            REG_TIMEOUT:   prdata = {48'd0, cfg_reg.timeout};
            REG_ORIENT:    prdata = {62'd0, cfg_reg.orient};
            REG_EDGE_SIZE: prdata = {32'd0, cfg_reg.edge_sizes};
            REG_SCREEN:    prdata = {32'd0, cfg_reg.screen_size};
            REG_TAB_LO:    prdata = {12'd0, cfg_reg.tab_lo};
            REG_TAB_HI:    prdata = {12'd0, cfg_reg.tab_hi};
            default:       prdata = '0;
        endcase
    end

    tsg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .slot     (slot),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    tsg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    tsg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .swipe_code   (swipe_code),
        .finger_count (finger_count),
        .edge_code    (edge_code),
        .match_mask   (match_mask)
    );

endmodule

### rtl/core/tsg_front.sv
module tsg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [3:0]           slot,
    input  logic [15:0]          pos_x,
    input  logic [15:0]          pos_y,
    input  logic                 q_full,
    output logic                 push,
    output tsg_pkg::job_t        push_job
);
    import tsg_pkg::*;

    logic [31:0]     start_pos_reg [SLOTS];
    logic [31:0]     end_pos_reg   [SLOTS];
    logic [SLOTS-1:0] start_valid_reg, start_valid_next;
    logic [SLOTS-1:0] end_valid_reg, end_valid_next;

    logic            accept;
    logic            slot_ok;
    logic [SLOT_W-1:0] idx;
    func_t           fn;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign fn       = func_t'(func);
    assign idx      = SLOT_W'(slot);
    assign slot_ok  = (32'(slot) < SLOTS);

    // Classify the event and build the queue entry
    always_comb
    begin
        start_valid_next = start_valid_reg;
        end_valid_next   = end_valid_reg;
        push             = 1'b0;
        push_job.func    = fn;
        push_job.up_ok   = start_valid_reg[idx] && end_valid_reg[idx];
        push_job.x0      = start_pos_reg[idx][15:0];
        push_job.y0      = start_pos_reg[idx][31:16];
        push_job.x1      = end_pos_reg[idx][15:0];
        push_job.y1      = end_pos_reg[idx][31:16];
        if (accept)
        begin
            case (fn)
                FN_TICK:
                begin
                    push = 1'b1;
                end
                FN_DOWN:
                begin
                    push = slot_ok;
                    if (slot_ok) start_valid_next[idx] = 1'b1;
                end
                FN_MOTION:
                begin
                    if (slot_ok) end_valid_next[idx] = 1'b1;
                end
                FN_UP:
                begin
                    push = slot_ok;
                    if (slot_ok)
                    begin
                        start_valid_next[idx] = 1'b0;
                        end_valid_next[idx]   = 1'b0;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_valid_reg <= '0;
            end_valid_reg   <= '0;
        end
        else
        begin
            start_valid_reg <= start_valid_next;
            end_valid_reg   <= end_valid_next;
        end
    end

    // Point store
    always_ff @(posedge clk)
    begin
        if (accept && slot_ok && fn == FN_DOWN)
            start_pos_reg[idx] <= {pos_y, pos_x};
        if (accept && slot_ok && fn == FN_MOTION)
            end_pos_reg[idx] <= {pos_y, pos_x};
    end

endmodule

### rtl/core/tsg_queue.sv
module tsg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsg_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tsg_pkg::job_t  head
);
    import tsg_pkg::*;

    job_t               mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/core/tsg_back.sv
module tsg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tsg_pkg::cfg_t  cfg,
    input  logic           q_empty,
    input  tsg_pkg::job_t  head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [3:0]     swipe_code,
    output logic [4:0]     finger_count,
    output logic [3:0]     edge_code,
    output logic [7:0]     match_mask
);
    import tsg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROT,
        ST_CLS,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [4:0]          fingers_reg, fingers_next;
    logic [4:0]          agree_reg, agree_next;
    logic [3:0]          pending_reg, pending_next;
    logic [15:0]         elapsed_reg, elapsed_next;
    job_t                job_reg, job_next;
    logic [33:0]         sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic [31:0]         thr2_reg, thr2_next;
    logic [3:0]          edge_reg, edge_next;
    logic [3:0]          swipe_reg, swipe_next;
    logic                zero_reg, zero_next;
    logic                flip_reg, flip_next;
    logic                qzero_reg, qzero_next;
    logic [16:0]         base_reg, base_next;
    logic signed [32:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [15:0]  cz_reg, cz_next;
    logic [3:0]          iter_reg, iter_next;
    logic                ov_reg, ov_next;
    logic [3:0]          o_swipe_reg, o_swipe_next;
    logic [4:0]          o_count_reg, o_count_next;
    logic [3:0]          o_edge_reg, o_edge_next;
    logic [7:0]          o_mask_reg, o_mask_next;

    assign out_valid    = ov_reg;
    assign swipe_code   = o_swipe_reg;
    assign finger_count = o_count_reg;
    assign edge_code    = o_edge_reg;
    assign match_mask   = o_mask_reg;

    always_comb
    begin
        logic signed [16:0] a, b;
        logic [15:0]        s, t;
        logic [16:0]        ex, ey, w, h;
        logic [3:0]         hz, vt;
        logic signed [32:0] ax, ay;
        logic signed [15:0] zc;
        logic [16:0]        ratio, d;
        logic [17:0]        len, dl, kk;
        logic [34:0]        dist2;
        logic [3:0]         sw;
        logic               hit;
        logic [4:0]         na;
        logic [3:0]         npend;
        logic [12:0]        ent;
        logic [7:0]         mask;

        state_next   = state_reg;
        fingers_next = fingers_reg;
        agree_next   = agree_reg;
        pending_next = pending_reg;
        elapsed_next = elapsed_reg;
        job_next     = job_reg;
        sqa_next     = sqa_reg;
        sqb_next     = sqb_reg;
        thr2_next    = thr2_reg;
        edge_next    = edge_reg;
        swipe_next   = swipe_reg;
        zero_next    = zero_reg;
        flip_next    = flip_reg;
        qzero_next   = qzero_reg;
        base_next    = base_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        iter_next    = iter_reg;
        ov_next      = ov_reg && out_stall;
        o_swipe_next = o_swipe_reg;
        o_count_next = o_count_reg;
        o_edge_next  = o_edge_reg;
        o_mask_next  = o_mask_reg;
        pop          = 1'b0;

        a  = $signed({1'b0, job_reg.x1}) - $signed({1'b0, job_reg.x0});
        b  = $signed({1'b0, job_reg.y0}) - $signed({1'b0, job_reg.y1});
        ex = {1'b0, cfg.edge_sizes[15:0]};
        ey = {1'b0, cfg.edge_sizes[31:16]};
        w  = {1'b0, cfg.screen_size[15:0]};
        h  = {1'b0, cfg.screen_size[31:16]};
        s  = '0;
        t  = '0;
        hz = EDGE_NONE;
        vt = EDGE_NONE;

        // One CORDIC rotation, shifts rounding toward zero
        ax = (cy_reg >= 0) ? (cy_reg >>> iter_reg) : -((-cy_reg) >>> iter_reg);
        ay = (cx_reg >= 0) ? (cx_reg >>> iter_reg) : -((-cx_reg) >>> iter_reg);

        // Angle assembly and window search
        if (qzero_reg)               zc = '0;
        else if (cz_reg < 0)         zc = '0;
        else if (cz_reg > 16'sd11520) zc = 16'sd11520;
        else                         zc = cz_reg;
        ratio = flip_reg ? (ANG_90 - 17'(zc)) : 17'(zc);
        d     = zero_reg ? '0 : (base_reg + ratio);
        len   = {2'b0, cfg.leniency, 8'd0};
        dl    = {1'b0, d} + len;
        dist2 = {1'b0, sqa_reg} + {1'b0, sqb_reg};
        sw    = SWIPE_NONE;
        hit   = 1'b0;
        for (int k = 0; k < 9; k++) begin
            kk = 18'(k * 11520);
            if (!hit && dl >= kk && {1'b0, d} <= kk + len)
            begin
                hit = 1'b1;
                sw  = window_code(4'(k));
            end
        end
        if (dist2 < {3'b0, thr2_reg}) sw = SWIPE_NONE;

        // Agreement update and table match for the finishing step
        npend = (agree_reg == '0) ? swipe_reg : pending_reg;
        na    = agree_reg;
        if (npend == swipe_reg && agree_reg < 5'd31) na = agree_reg + 1'b1;
        mask = '0;
        for (int i = 0; i < GESTURE_ENTRIES; i++) begin
            ent = (i < 4) ? cfg.tab_lo[ENTRY_W*(i%4) +: ENTRY_W]
                          : cfg.tab_hi[ENTRY_W*(i%4) +: ENTRY_W];
            if (ent[12] && ent[11:7] == na
                && {1'b0, rot_swipe(ent[6:4], cfg.orient)} == swipe_reg
                && (rot_edge(ent[3:0], cfg.orient) == EDGE_ANY
                    || rot_edge(ent[3:0], cfg.orient) == edge_reg))
                mask[i] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (head.func)
                        FN_TICK:
                        begin
                            if (elapsed_reg != 16'hFFFF) elapsed_next = elapsed_reg + 1'b1;
                        end
                        FN_DOWN:
                        begin
                            if (fingers_reg == '0) elapsed_next = '0;
                            if (fingers_reg < 5'd31) fingers_next = fingers_reg + 1'b1;
                        end
                        FN_UP:
                        begin
                            if (fingers_reg != '0) fingers_next = fingers_reg - 1'b1;
                            if (head.up_ok)
                            begin
                                job_next   = head;
                                state_next = ST_SQ;
                            end
                        end
                        default:
                        begin
                            fingers_next = fingers_reg;
                        end
                    endcase
                end
            end

            ST_SQ:
            begin
                // Squares, edge band and quadrant reduction
                sqa_next  = 34'(a * a);
                sqb_next  = 34'(b * b);
                thr2_next = cfg.dist_thr * cfg.dist_thr;
                if ({1'b0, job_reg.x0} <= ex)           hz = EDGE_LEFT;
                else if ({1'b0, job_reg.x0} + ex >= w)  hz = EDGE_RIGHT;
                else if ({1'b0, job_reg.x1} <= ex)      hz = EDGE_LEFT;
                else if ({1'b0, job_reg.x1} + ex >= w)  hz = EDGE_RIGHT;
                if ({1'b0, job_reg.y0} <= ey)           vt = EDGE_TOP;
                else if ({1'b0, job_reg.y0} + ey >= h)  vt = EDGE_BOTTOM;
                else if ({1'b0, job_reg.y1} <= ey)      vt = EDGE_TOP;
                else if ({1'b0, job_reg.y1} + ey >= h)  vt = EDGE_BOTTOM;
                if (hz == EDGE_LEFT && vt == EDGE_TOP)          edge_next = EDGE_TL;
                else if (hz == EDGE_RIGHT && vt == EDGE_TOP)    edge_next = EDGE_TR;
                else if (hz == EDGE_LEFT && vt == EDGE_BOTTOM)  edge_next = EDGE_BL;
                else if (hz == EDGE_RIGHT && vt == EDGE_BOTTOM) edge_next = EDGE_BR;
                else edge_next = (hz != EDGE_NONE) ? hz : vt;

                zero_next = (a == 0) && (b == 0);
                if (a >= 0 && b > 0)
                begin
                    s = a[15:0]; t = b[15:0]; base_next = '0;
                end
                else if (a > 0)
                begin
                    s = 16'(-b); t = a[15:0]; base_next = ANG_90;
                end
                else if (b < 0)
                begin
                    s = 16'(-a); t = 16'(-b); base_next = ANG_180;
                end
                else
                begin
                    s = b[15:0]; t = 16'(-a); base_next = ANG_270;
                end
                flip_next  = (s > t);
                qzero_next = (s > t) ? (t == '0) : (s == '0);
                cx_next    = $signed({3'b0, ((s > t) ? s : t), 14'd0});
                cy_next    = $signed({3'b0, ((s > t) ? t : s), 14'd0});
                cz_next    = '0;
                iter_next  = '0;
                state_next = ST_ROT;
            end

            ST_ROT:
            begin
                if (cy_reg >= 0)
                begin
                    cx_next = cx_reg + ax;
                    cy_next = cy_reg - ay;
                    cz_next = cz_reg + $signed({2'b0, atan_step(iter_reg)});
                end
                else
                begin
                    cx_next = cx_reg - ax;
                    cy_next = cy_reg + ay;
                    cz_next = cz_reg - $signed({2'b0, atan_step(iter_reg)});
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 4'(CORDIC_STEPS - 1)) state_next = ST_CLS;
            end

            ST_CLS:
            begin
                swipe_next = sw;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (fingers_reg != '0)
                begin
                    pending_next = npend;
                    agree_next   = na;
                    state_next   = ST_IDLE;
                end
                else if (elapsed_reg >= cfg.timeout)
                begin
                    pending_next = npend;
                    agree_next   = '0;
                    state_next   = ST_IDLE;
                end
                else if (!(ov_reg && out_stall))
                begin
                    pending_next = npend;
                    agree_next   = '0;
                    ov_next      = 1'b1;
                    o_swipe_next = swipe_reg;
                    o_count_next = na;
                    o_edge_next  = edge_reg;
                    o_mask_next  = mask;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fingers_reg <= '0;
            agree_reg   <= '0;
            pending_reg <= '0;
            elapsed_reg <= '0;
            job_reg     <= '0;
            sqa_reg     <= '0;
            sqb_reg     <= '0;
            thr2_reg    <= '0;
            edge_reg    <= '0;
            swipe_reg   <= '0;
            zero_reg    <= 1'b0;
            flip_reg    <= 1'b0;
            qzero_reg   <= 1'b0;
            base_reg    <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            cz_reg      <= '0;
            iter_reg    <= '0;
            ov_reg      <= 1'b0;
            o_swipe_reg <= '0;
            o_count_reg <= '0;
            o_edge_reg  <= '0;
            o_mask_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fingers_reg <= fingers_next;
            agree_reg   <= agree_next;
            pending_reg <= pending_next;
            elapsed_reg <= elapsed_next;
            job_reg     <= job_next;
            sqa_reg     <= sqa_next;
            sqb_reg     <= sqb_next;
            thr2_reg    <= thr2_next;
            edge_reg    <= edge_next;
            swipe_reg   <= swipe_next;
            zero_reg    <= zero_next;
            flip_reg    <= flip_next;
            qzero_reg   <= qzero_next;
            base_reg    <= base_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            cz_reg      <= cz_next;
            iter_reg    <= iter_next;
            ov_reg      <= ov_next;
            o_swipe_reg <= o_swipe_next;
            o_count_reg <= o_count_next;
            o_edge_reg  <= o_edge_next;
            o_mask_reg  <= o_mask_next;
        end
    end

endmodule

### dv/touch_swipe_gesture_recognizer_test.sv
`timescale 1ns / 1ps

module touch_swipe_gesture_recognizer_test;
    import tsg_pkg::*;

    // Gesture report as seen on the result port
    typedef struct packed {
        logic [3:0] swipe;
        logic [4:0] count;
        logic [3:0] edge_c;
        logic [7:0] mask;
    } report_t;

    typedef struct packed {
        func_t       fn;
        logic [3:0]  sl;
        logic [15:0] x;
        logic [15:0] y;
    } touch_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  swipe_code;
    logic [4:0]  finger_count;
    logic [3:0]  edge_code;
    logic [7:0]  match_mask;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Captures whether the last rising edge stalled the input transfer
    logic        in_stall_seen;

    touch_swipe_gesture_recognizer uut (.*);

    // Shadow copy of configuration and tracking state
    logic [15:0] thr_q;
    logic [7:0]  len_q;
    logic [15:0] tmo_q;
    logic [1:0]  ori_q;
    logic [31:0] edg_q;
    logic [31:0] scr_q;
    logic [51:0] tlo_q;
    logic [51:0] thi_q;
    logic [31:0] p0_q [16];
    logic [31:0] p1_q [16];
    logic        v0_q [16];
    logic        v1_q [16];
    logic [4:0]  down_q;
    logic [4:0]  agree_q;
    logic [3:0]  pend_q;
    logic [15:0] ms_q;

    touch_t  touch_queue[$];
    report_t report_queue[$];
    int      fail_count;
    int      gap_in;
    int      gap_out;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s at %0t", msg, $realtime);
        fail_count++;
    endtask

    function automatic longint shift_tz(input longint v, input int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    // Vectoring CORDIC, atan(q/p) in 1/256 degree
    function automatic longint vec_atan(input longint p, input longint q);
        longint x, y, z, ax, ay;
        longint steps [15] = '{11520, 6801, 3593, 1824, 916, 458, 229, 115, 57, 29,
                               14, 7, 4, 2, 1};
        x = p * 16384;
        y = q * 16384;
        z = 0;
        if (q == 0) return 0;
        for (int i = 0; i < 15; i++) begin
            ax = shift_tz(y, i);
            ay = shift_tz(x, i);
            if (y >= 0)
            begin
                x += ax; y -= ay; z += steps[i];
            end
            else
            begin
                x -= ax; y += ay; z -= steps[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 11520) z = 11520;
        return z;
    endfunction

    function automatic longint ratio_angle(input longint s, input longint t);
        if (s <= t) return vec_atan(t, s);
        return 23040 - vec_atan(s, t);
    endfunction

    function automatic logic [3:0] swipe_dir(input longint x0, input longint y0,
                                             input longint x1, input longint y1);
        longint a, b, d, lo, hi, lw;
        logic [3:0] codes [9] = '{0, 4, 2, 7, 1, 6, 3, 5, 0};
        a = x1 - x0;
        b = y0 - y1;
        lw = longint'(len_q) * 256;
        if (a * a + b * b < longint'(thr_q) * longint'(thr_q)) return SWIPE_NONE;
        if (a == 0 && b == 0) d = 0;
        else if (a >= 0 && b > 0) d = ratio_angle(a, b);
        else if (a > 0) d = 23040 + ratio_angle(-b, a);
        else if (b < 0) d = 46080 + ratio_angle(-a, -b);
        else d = 69120 + ratio_angle(b, -a);
        for (int k = 0; k < 9; k++) begin
            lo = k * 11520 - lw;
            hi = k * 11520 + lw;
            if (d >= lo && d <= hi) return codes[k];
        end
        return SWIPE_NONE;
    endfunction

    function automatic logic [3:0] edge_hit(input longint x0, input longint y0,
                                            input longint x1, input longint y1);
        longint ex, ey, w, h;
        logic [3:0] hz, vt;
        ex = edg_q[15:0]; ey = edg_q[31:16];
        w = scr_q[15:0];  h = scr_q[31:16];
        hz = EDGE_NONE;
        vt = EDGE_NONE;
        if (x0 <= ex) hz = EDGE_LEFT;
        else if (x0 >= w - ex) hz = EDGE_RIGHT;
        else if (x1 <= ex) hz = EDGE_LEFT;
        else if (x1 >= w - ex) hz = EDGE_RIGHT;
        if (y0 <= ey) vt = EDGE_TOP;
        else if (y0 >= h - ey) vt = EDGE_BOTTOM;
        else if (y1 <= ey) vt = EDGE_TOP;
        else if (y1 >= h - ey) vt = EDGE_BOTTOM;
        if (hz == EDGE_LEFT && vt == EDGE_TOP) return EDGE_TL;
        if (hz == EDGE_RIGHT && vt == EDGE_TOP) return EDGE_TR;
        if (hz == EDGE_LEFT && vt == EDGE_BOTTOM) return EDGE_BL;
        if (hz == EDGE_RIGHT && vt == EDGE_BOTTOM) return EDGE_BR;
        return hz != EDGE_NONE ? hz : vt;
    endfunction

    // Table match with the orientation applied to each entry
    function automatic logic [7:0] table_hits(input logic [3:0] sw, input logic [4:0] cnt,
                                              input logic [3:0] ed);
        logic [7:0]  m;
        logic [12:0] ent;
        logic [2:0]  es;
        logic [3:0]  ee;
        logic [2:0]  sturn [8] = '{2, 3, 1, 0, 7, 4, 5, 6};
        logic [3:0]  eturn [16] = '{0, 1, 4, 5, 3, 2, 7, 9, 6, 8, 10, 11, 12, 13, 14, 15};
        m = '0;
        for (int i = 0; i < 8; i++) begin
            ent = (i < 4) ? tlo_q[13*i +: 13] : thi_q[13*(i-4) +: 13];
            es = ent[6:4];
            ee = ent[3:0];
            for (int r = 0; r < ori_q; r++) begin
                es = sturn[es];
                ee = eturn[ee];
            end
            if (ent[12] && ent[11:7] == cnt && {1'b0, es} == sw &&
                (ee == EDGE_ANY || ee == ed))
                m[i] = 1'b1;
        end
        return m;
    endfunction

    // Advance the shadow state by one accepted event
    task automatic track_touch(input touch_t t);
        logic [3:0] sw, ed;
        longint x0, y0, x1, y1;
        report_t r;
        case (t.fn)
            FN_TICK:
                if (ms_q != 16'hFFFF) ms_q++;
            FN_DOWN:
            begin
                p0_q[t.sl] = {t.y, t.x};
                v0_q[t.sl] = 1'b1;
                if (down_q == 0) ms_q = 0;
                if (down_q < 31) down_q++;
            end
            FN_MOTION:
            begin
                p1_q[t.sl] = {t.y, t.x};
                v1_q[t.sl] = 1'b1;
            end
            default:
            begin
                if (down_q > 0) down_q--;
                if (v0_q[t.sl] && v1_q[t.sl])
                begin
                    x0 = p0_q[t.sl][15:0]; y0 = p0_q[t.sl][31:16];
                    x1 = p1_q[t.sl][15:0]; y1 = p1_q[t.sl][31:16];
                    sw = swipe_dir(x0, y0, x1, y1);
                    ed = edge_hit(x0, y0, x1, y1);
                    if (agree_q == 0) pend_q = sw;
                    if (pend_q == sw && agree_q < 31) agree_q++;
                    v0_q[t.sl] = 1'b0;
                    v1_q[t.sl] = 1'b0;
                    if (down_q == 0)
                    begin
                        if (ms_q < tmo_q)
                        begin
                            r.swipe = sw;
                            r.count = agree_q;
                            r.edge_c = ed;
                            r.mask = table_hits(sw, agree_q, ed);
                            report_queue.push_back(r);
                        end
                        agree_q = 0;
                    end
                end
            end
        endcase
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 3'b000}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_DIST_THR:  thr_q = val[15:0];
            REG_LENIENCY:  len_q = val[7:0];
            REG_TIMEOUT:   tmo_q = val[15:0];
            REG_ORIENT:    ori_q = val[1:0];
            REG_EDGE_SIZE: edg_q = val[31:0];
            REG_SCREEN:    scr_q = val[31:0];
            REG_TAB_LO:    tlo_q = val[51:0];
            default:       thi_q = val[51:0];
        endcase
    endtask

    // Wait for the pipeline to drain before touching registers;
    // the tail covers a full queue of lifts that produce no result
    task automatic drain();
        while (touch_queue.size() != 0 || report_queue.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic push_touch(input func_t f, input logic [3:0] s,
                              input logic [15:0] x, input logic [15:0] y);
        touch_t t;
        t.fn = f; t.sl = s; t.x = x; t.y = y;
        touch_queue.push_back(t);
    endtask

    function automatic logic [51:0] rand_table();
        logic [51:0] v;
        logic [12:0] e;
        for (int k = 0; k < 4; k++) begin
            e[12] = ($urandom_range(0, 3) != 0);
            e[11:7] = 5'($urandom_range(1, 4));
            e[6:4] = 3'($urandom_range(0, 7));
            e[3:0] = ($urandom_range(0, 1) != 0) ? EDGE_ANY : 4'($urandom_range(0, 15));
            v[13*k +: 13] = e;
        end
        return v;
    endfunction

    // A full gesture of one to four fingers with random geometry
    task automatic push_gesture();
        int n, ticks;
        logic [3:0] s [4];
        logic [15:0] bx, by;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s[i] = 4'(4 * i + $urandom_range(0, 3));
        for (int i = 0; i < n; i++) begin
            bx = 16'($urandom);
            by = 16'($urandom);
            push_touch(FN_DOWN, s[i], bx, by);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) != 0)
                push_touch(FN_MOTION, s[i], 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                push_touch(FN_MOTION, s[i], 16'($urandom_range(0, 65535)), 16'($urandom));
        end
        ticks = $urandom_range(0, 3);
        for (int i = 0; i < ticks; i++)
            push_touch(FN_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
        for (int i = 0; i < n; i++)
            push_touch(FN_UP, s[i], 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input monitor feeding the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            track_touch(touch_t'({func_t'(func), slot, pos_x, pos_y}));
    end

    // Input driver
    always @(negedge clk)
    begin
        logic ready;
        if (rst_n)
        begin
            ready = !in_valid || !in_stall_seen;
            if (in_valid && !in_stall_seen)
            begin
                void'(touch_queue.pop_front());
                gap_in = $urandom_range(0, 3);
                if ($urandom_range(0, 7) == 0) gap_in = 0;
            end
            if (ready)
            begin
                if (gap_in > 0)
                begin
                    gap_in--;
                    in_valid <= 1'b0;
                end
                else if (touch_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    func <= touch_queue[0].fn;
                    slot <= touch_queue[0].sl;
                    pos_x <= touch_queue[0].x;
                    pos_y <= touch_queue[0].y;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
        in_stall_seen <= in_stall;

    // Result monitor and stall generator
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_queue.size() == 0)
            begin
                report_mismatch("unexpected result");
            end
            else
            begin
                want = report_queue.pop_front();
                if (swipe_code !== want.swipe)
                    report_mismatch($sformatf("swipe: got %0d expected %0d",
                                              swipe_code, want.swipe));
                if (finger_count !== want.count)
                    report_mismatch($sformatf("count: got %0d expected %0d",
                                              finger_count, want.count));
                if (edge_code !== want.edge_c)
                    report_mismatch($sformatf("edge: got %0d expected %0d",
                                              edge_code, want.edge_c));
                if (match_mask !== want.mask)
                    report_mismatch($sformatf("mask: got %0d expected %0d",
                                              match_mask, want.mask));
            end
        end
    end

    always @(negedge clk)
    begin
        if (gap_out > 0)
        begin
            gap_out--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid) gap_out = $urandom_range(0, 1) ? $urandom_range(0, 3) : 0;
        end
    end

    // Stimulus and configuration phases
    initial
    begin
        logic [15:0] thr_set [4] = '{0, 200, 65535, 30};
        rst_n = 1'b0;
        in_valid = 1'b0; func = '0; slot = '0; pos_x = '0; pos_y = '0;
        out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; gap_in = 0; gap_out = 0;
        thr_q = 200; len_q = 20; tmo_q = 400; ori_q = 0;
        edg_q = 32'd3276850; scr_q = 0; tlo_q = 0; thi_q = 0;
        for (int i = 0; i < 16; i++) begin
            p0_q[i] = 0; p1_q[i] = 0; v0_q[i] = 0; v1_q[i] = 0;
        end
        down_q = 0; agree_q = 0; pend_q = 0; ms_q = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one finger in seven of the eight directions, lift without motion,
        // up on an empty slot, zero-length and full-range swipes
        reg_write(REG_SCREEN, 64'({16'd1000, 16'd1000}));
        reg_write(REG_TAB_LO, 64'({13'h0, 13'h0, 13'h0, 1'b1, 5'd1, 3'd2, EDGE_ANY}));
        push_touch(FN_UP, 4'd3, 16'd0, 16'd0);
        push_touch(FN_DOWN, 4'd0, 16'd500, 16'd500);
        push_touch(FN_UP, 4'd0, 16'd0, 16'd0);
        for (int k = 0; k < 8; k++) begin
            push_touch(FN_DOWN, 4'd1, 16'd500, 16'd500);
            push_touch(FN_MOTION, 4'd1, 16'(500 + (k % 3 - 1) * 300),
                       16'(500 + (k / 3 - 1) * 300));
            push_touch(FN_UP, 4'd1, 16'd0, 16'd0);
        end
        push_touch(FN_DOWN, 4'd15, 16'd0, 16'd0);
        push_touch(FN_MOTION, 4'd15, 16'hFFFF, 16'hFFFF);
        push_touch(FN_UP, 4'd15, 16'd0, 16'd0);
        push_touch(FN_DOWN, 4'd2, 16'd7, 16'd7);
        push_touch(FN_MOTION, 4'd2, 16'd7, 16'd7);
        push_touch(FN_UP, 4'd2, 16'd0, 16'd0);
        drain();

        // Random phases over a spread of settings
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_DIST_THR,
                      64'((ph < 4) ? thr_set[ph] : 16'($urandom_range(0, 3000))));
            reg_write(REG_LENIENCY,
                      64'((ph == 1) ? 0 : (ph == 2) ? 180 : $urandom_range(5, 30)));
            reg_write(REG_TIMEOUT,
                      64'((ph == 3) ? 0 : (ph == 4) ? 65535 : $urandom_range(3, 20)));
            reg_write(REG_ORIENT, 64'(ph % 4));
            reg_write(REG_EDGE_SIZE, 64'((ph == 5) ? 32'hFFFF_FFFF : $urandom));
            reg_write(REG_SCREEN, 64'((ph == 6) ? 32'hFFFF_FFFF : $urandom));
            reg_write(REG_TAB_LO, 64'(rand_table()));
            reg_write(REG_TAB_HI, 64'(rand_table()));
            for (int g = 0; g < 28; g++) begin
                if ($urandom_range(0, 9) == 0)
                    push_touch(func_t'(2'($urandom_range(0, 3))), 4'($urandom),
                               16'($urandom), 16'($urandom));
                else
                    push_gesture();
            end
            drain();
        end

        repeat (100) @(negedge clk);
        if (report_queue.size() != 0) report_mismatch("expected results never seen");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/core/tsg_pkg.sv
rtl/core/tsg_front.sv
rtl/core/tsg_queue.sv
rtl/core/tsg_back.sv
rtl/core/touch_swipe_gesture_recognizer.sv
dv/touch_swipe_gesture_recognizer_test.sv
